@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the rtl, empty when synthesizing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/lrukec_pkg.sv @@
// types, field widths and codes of the lru keyed entry cache
`timescale 1ns / 1ps

package lrukec_pkg;

    // default directory depth
    localparam int DEFAULT_DEPTH = 16;

    // field widths
    localparam int OPCODE_W = 3;
    localparam int KIND_W   = 2;
    localparam int KEY_W    = 32;
    localparam int COLOR_W  = 32;
    localparam int FRAME_W  = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 5;
    localparam int CAP_W    = 5;

    // operation codes
    localparam logic [OPCODE_W-1:0] OP_OPEN    = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_INV_KEY = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_INV_ALL = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_TRIM    = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_EVICT   = 3'd4;

    // source kinds that can match
    localparam logic [KIND_W-1:0] KIND_VAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FILE = 2'd1;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_HIT         = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_INSERTED    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_DISABLED    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_OPEN_FAILED = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_DONE        = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_NO_EVICT    = 3'd5;

    // one directory entry as stored
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [KEY_W-1:0]   key;
        logic [COLOR_W-1:0] color;
        logic [FRAME_W-1:0] frame;
    } t_entry;

    // rank rewrite applied by an update scan
    typedef enum logic [2:0] {
        UPD_HIT = 3'b001,
        UPD_INS = 3'b010,
        UPD_DEC = 3'b100
    } t_upd_mode;

endpackage

@@ rtl/core/lru_keyed_entry_cache.sv @@
// lru keyed entry cache directory with a slot-serial scan engine
`timescale 1ns / 1ps

`include "assert_macros.svh"

// Directory of up to DEPTH keyed entries in least-recently-used order. A command
// is taken when start is high and busy is low; its single result is shown on the
// o_ ports for exactly one cycle with o_valid, and the receiver cannot hold it off.
// The block handles one command at a time: entry data and recency ranks sit in two
// memories that one compare and rank-update unit walks slot by slot. An open runs a
// search scan and a decide step; a hit then runs a rank scan, and an insert a rank
// scan and an insert step. A failed open and evict end after the decide step, trim
// repeats search and decide per entry removed, and invalidate key runs search,
// decide and a rank scan per entry removed, then a last search and decide. A
// disabled open, invalidate all, an unknown code, invalidate key of a kind that never
// matches, trim with nothing over capacity and evict on an empty directory are
// answered from idle with no scan. Capacity writes are taken at any time but
// must come while idle.
module lru_keyed_entry_cache #(
    parameter int DEPTH = lrukec_pkg::DEFAULT_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [lrukec_pkg::CAP_W-1:0]         i_cfg_wdata,
    // command beat
    input  logic                                 start,
    output logic                                 busy,
    input  logic [lrukec_pkg::OPCODE_W-1:0]      i_opcode,
    input  logic [lrukec_pkg::KIND_W-1:0]        i_key_kind,
    input  logic [lrukec_pkg::KEY_W-1:0]         i_source_key,
    input  logic [lrukec_pkg::COLOR_W-1:0]       i_color,
    input  logic signed [lrukec_pkg::FRAME_W-1:0] i_frame_number,
    input  logic                                 i_decode_ok,
    // result beat
    output logic                                 o_valid,
    output logic [lrukec_pkg::STATUS_W-1:0]      o_status,
    output logic [lrukec_pkg::SLOT_W-1:0]        o_slot,
    output logic                                 o_evicted,
    output logic [lrukec_pkg::SLOT_W-1:0]        o_evicted_slot,
    output logic [lrukec_pkg::COUNT_W-1:0]       o_removed_count,
    output logic [lrukec_pkg::COUNT_W-1:0]       o_entries_used
);
    import lrukec_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [IW-1:0] LAST_IDX  = IW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_FIND   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_INSERT = 5'b10000
    } t_state;

    // sequencer and architectural state
    t_state              r_state, n_state;
    logic [CAP_W-1:0]    r_cap, n_cap;
    logic [DEPTH-1:0]    r_valid, n_valid;
    logic [CW-1:0]       r_used, n_used;

    // latched command
    logic [OPCODE_W-1:0] r_op, n_op;
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [COLOR_W-1:0]  r_color, n_color;
    logic [FRAME_W-1:0]  r_frame, n_frame;
    logic                r_dok, n_dok;

    // scan engine
    logic [IW-1:0]       r_cnt, n_cnt;
    logic                r_issue, n_issue;
    logic                r_proc, n_proc;
    logic [IW-1:0]       r_pidx, n_pidx;
    logic                start_pass;
    logic                pass_end;

    // memory read data
    t_entry              r_rd_entry;
    logic [IW-1:0]       r_rd_rank;

    // scan results
    logic                r_hit_f, n_hit_f;
    logic [IW-1:0]       r_hit_slot, n_hit_slot;
    logic [IW-1:0]       r_hit_rank, n_hit_rank;
    logic                r_tail_f, n_tail_f;
    logic [IW-1:0]       r_tail_slot, n_tail_slot;
    logic [IW-1:0]       r_tail_rank, n_tail_rank;
    logic                r_free_f, n_free_f;
    logic [IW-1:0]       r_free_slot, n_free_slot;

    // update scan control
    t_upd_mode           r_mode, n_mode;
    logic [IW-1:0]       r_urank, n_urank;
    logic [IW-1:0]       r_uslot, n_uslot;
    logic [IW-1:0]       r_ins_slot, n_ins_slot;

    // result registers
    logic                r_out_vld, n_out_vld;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [IW-1:0]       r_slot, n_slot;
    logic                r_ev, n_ev;
    logic [IW-1:0]       r_evslot, n_evslot;
    logic [CW-1:0]       r_removed, n_removed;

    // memories
    t_entry              mem_entry [DEPTH];
    logic [IW-1:0]       mem_rank  [DEPTH];

    // shared per-slot unit
    logic                p_valid;
    logic                kind_ok;
    logic                key_eq;
    logic                full_eq;
    logic                take_hit;
    logic                take_tail;
    logic                take_free;
    logic                upd_we;
    logic [IW-1:0]       upd_rank;
    logic                rank_we;
    logic [IW-1:0]       rank_addr;
    logic [IW-1:0]       rank_data;

    // occupancy checks
    logic [CW-1:0]       used_dec;
    logic                cache_full;
    logic                over_cap;
    logic                evict_now;

    assign used_dec   = r_used - 1'b1;
    assign cache_full = (KW'(r_used) >= KW'(r_cap)) || (r_used == DEPTH_CNT);
    assign over_cap   = KW'(r_used) > KW'(r_cap);
    assign evict_now  = cache_full && r_tail_f;
    assign pass_end   = r_proc && (r_pidx == LAST_IDX);

    // compare of the slot coming out of the memories
    always_comb begin
        p_valid   = r_valid[r_pidx];
        kind_ok   = r_kind inside {KIND_VAR, KIND_FILE};
        key_eq    = kind_ok && (r_rd_entry.kind == r_kind) && (r_rd_entry.key == r_key);
        full_eq   = key_eq && (r_rd_entry.color == r_color) && (r_rd_entry.frame == r_frame);
        take_hit  = p_valid && ((r_op == OP_OPEN) ? full_eq : key_eq)
                    && (!r_hit_f || (r_rd_rank < r_hit_rank));
        take_tail = p_valid && (!r_tail_f || (r_rd_rank > r_tail_rank));
        take_free = !p_valid && !r_free_f;
    end

    // rank rewrite of the slot coming out of the memories
    always_comb begin
        upd_we   = 1'b0;
        upd_rank = r_rd_rank;
        case (r_mode)
            UPD_HIT: begin
                if (r_pidx == r_uslot) begin
                    upd_we   = 1'b1;
                    upd_rank = '0;
                end else if (p_valid && (r_rd_rank < r_urank)) begin
                    upd_we   = 1'b1;
                    upd_rank = r_rd_rank + 1'b1;
                end
            end
            UPD_INS: begin
                if (p_valid) begin
                    upd_we   = 1'b1;
                    upd_rank = r_rd_rank + 1'b1;
                end
            end
            UPD_DEC: begin
                if (p_valid && (r_rd_rank > r_urank)) begin
                    upd_we   = 1'b1;
                    upd_rank = r_rd_rank - 1'b1;
                end
            end
            default: begin
                upd_we = 1'b0;
            end
        endcase
    end

    // rank memory write port
    always_comb begin
        rank_we   = 1'b0;
        rank_addr = r_pidx;
        rank_data = upd_rank;
        if (r_state == ST_UPDATE) begin
            rank_we = r_proc && upd_we;
        end else if (r_state == ST_INSERT) begin
            rank_we   = 1'b1;
            rank_addr = r_ins_slot;
            rank_data = '0;
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_cap       = r_cap;
        n_valid     = r_valid;
        n_used      = r_used;
        n_op        = r_op;
        n_kind      = r_kind;
        n_key       = r_key;
        n_color     = r_color;
        n_frame     = r_frame;
        n_dok       = r_dok;
        n_hit_f     = r_hit_f;
        n_hit_slot  = r_hit_slot;
        n_hit_rank  = r_hit_rank;
        n_tail_f    = r_tail_f;
        n_tail_slot = r_tail_slot;
        n_tail_rank = r_tail_rank;
        n_free_f    = r_free_f;
        n_free_slot = r_free_slot;
        n_mode      = r_mode;
        n_urank     = r_urank;
        n_uslot     = r_uslot;
        n_ins_slot  = r_ins_slot;
        n_out_vld   = 1'b0;
        n_status    = r_status;
        n_slot      = r_slot;
        n_ev        = r_ev;
        n_evslot    = r_evslot;
        n_removed   = r_removed;
        start_pass  = 1'b0;

        // capacity register
        if (i_cfg_we) begin
            n_cap = i_cfg_wdata;
        end

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_op      = i_opcode;
                    n_kind    = i_key_kind;
                    n_key     = i_source_key;
                    n_color   = i_color;
                    n_frame   = $unsigned(i_frame_number);
                    n_dok     = i_decode_ok;
                    n_status  = STAT_DONE;
                    n_slot    = '0;
                    n_ev      = 1'b0;
                    n_evslot  = '0;
                    n_removed = '0;
                    case (i_opcode)
                        OP_OPEN: begin
                            if (r_cap == '0) begin
                                n_status  = STAT_DISABLED;
                                n_out_vld = 1'b1;
                            end else begin
                                n_state    = ST_FIND;
                                start_pass = 1'b1;
                            end
                        end
                        OP_INV_KEY: begin
                            if (i_key_kind inside {KIND_VAR, KIND_FILE}) begin
                                n_state    = ST_FIND;
                                start_pass = 1'b1;
                            end else begin
                                n_out_vld = 1'b1;
                            end
                        end
                        OP_INV_ALL: begin
                            n_removed = r_used;
                            n_valid   = '0;
                            n_used    = '0;
                            n_out_vld = 1'b1;
                        end
                        OP_TRIM: begin
                            if (over_cap) begin
                                n_state    = ST_FIND;
                                start_pass = 1'b1;
                            end else begin
                                n_out_vld = 1'b1;
                            end
                        end
                        OP_EVICT: begin
                            if (r_used == '0) begin
                                n_status  = STAT_NO_EVICT;
                                n_out_vld = 1'b1;
                            end else begin
                                n_state    = ST_FIND;
                                start_pass = 1'b1;
                            end
                        end
                        default: begin
                            n_out_vld = 1'b1;
                        end
                    endcase
                end
            end

            // search scan: best match, least recent, lowest free slot
            ST_FIND: begin
                if (r_proc) begin
                    if (take_hit) begin
                        n_hit_f    = 1'b1;
                        n_hit_slot = r_pidx;
                        n_hit_rank = r_rd_rank;
                    end
                    if (take_tail) begin
                        n_tail_f    = 1'b1;
                        n_tail_slot = r_pidx;
                        n_tail_rank = r_rd_rank;
                    end
                    if (take_free) begin
                        n_free_f    = 1'b1;
                        n_free_slot = r_pidx;
                    end
                end
                if (pass_end) begin
                    n_state = ST_DECIDE;
                end
            end

            ST_DECIDE: begin
                n_state = ST_IDLE;
                case (r_op)
                    OP_OPEN: begin
                        if (r_hit_f) begin
                            n_status   = STAT_HIT;
                            n_slot     = r_hit_slot;
                            n_mode     = UPD_HIT;
                            n_urank    = r_hit_rank;
                            n_uslot    = r_hit_slot;
                            n_state    = ST_UPDATE;
                            start_pass = 1'b1;
                        end else if (!r_dok) begin
                            n_status  = STAT_OPEN_FAILED;
                            n_out_vld = 1'b1;
                        end else begin
                            n_status = STAT_INSERTED;
                            // full cache drops its least recent entry first
                            if (evict_now) begin
                                n_valid[r_tail_slot] = 1'b0;
                                n_used               = used_dec;
                                n_ev                 = 1'b1;
                                n_evslot             = r_tail_slot;
                                n_removed            = CW'(1);
                            end
                            // lowest free slot, counting the one just evicted
                            if (r_free_f && (!evict_now || (r_free_slot < r_tail_slot))) begin
                                n_ins_slot = r_free_slot;
                                n_mode     = UPD_INS;
                                n_state    = ST_UPDATE;
                                start_pass = 1'b1;
                            end else if (evict_now) begin
                                n_ins_slot = r_tail_slot;
                                n_mode     = UPD_INS;
                                n_state    = ST_UPDATE;
                                start_pass = 1'b1;
                            end else begin
                                n_out_vld = 1'b1;
                            end
                        end
                    end
                    OP_INV_KEY: begin
                        if (r_hit_f) begin
                            n_valid[r_hit_slot] = 1'b0;
                            n_used              = used_dec;
                            n_removed           = r_removed + 1'b1;
                            n_mode              = UPD_DEC;
                            n_urank             = r_hit_rank;
                            n_state             = ST_UPDATE;
                            start_pass          = 1'b1;
                        end else begin
                            n_out_vld = 1'b1;
                        end
                    end
                    OP_TRIM: begin
                        // least recent holds the top rank, no renumbering needed
                        if (r_tail_f) begin
                            n_valid[r_tail_slot] = 1'b0;
                            n_used               = used_dec;
                            n_removed            = r_removed + 1'b1;
                            if (KW'(used_dec) > KW'(r_cap)) begin
                                n_state    = ST_FIND;
                                start_pass = 1'b1;
                            end else begin
                                n_out_vld = 1'b1;
                            end
                        end else begin
                            n_out_vld = 1'b1;
                        end
                    end
                    OP_EVICT: begin
                        if (r_tail_f) begin
                            n_valid[r_tail_slot] = 1'b0;
                            n_used               = used_dec;
                            n_removed            = CW'(1);
                        end else begin
                            n_status = STAT_NO_EVICT;
                        end
                        n_out_vld = 1'b1;
                    end
                    default: begin
                        n_out_vld = 1'b1;
                    end
                endcase
            end

            // rank rewrite scan
            ST_UPDATE: begin
                if (pass_end) begin
                    case (r_mode)
                        UPD_INS: begin
                            n_state = ST_INSERT;
                        end
                        UPD_DEC: begin
                            n_state    = ST_FIND;
                            start_pass = 1'b1;
                        end
                        default: begin
                            n_state   = ST_IDLE;
                            n_out_vld = 1'b1;
                        end
                    endcase
                end
            end

            // new entry goes in as most recent
            ST_INSERT: begin
                n_valid[r_ins_slot] = 1'b1;
                n_used              = r_used + 1'b1;
                n_slot              = r_ins_slot;
                n_out_vld           = 1'b1;
                n_state             = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // clear the scan results when a search begins
        if (start_pass && (n_state == ST_FIND)) begin
            n_hit_f  = 1'b0;
            n_tail_f = 1'b0;
            n_free_f = 1'b0;
        end
    end

    // scan address generation, processing follows issue in the cycle after
    always_comb begin
        n_cnt   = r_cnt;
        n_issue = r_issue;
        n_proc  = r_issue;
        n_pidx  = r_cnt;
        if (start_pass) begin
            n_cnt   = '0;
            n_issue = 1'b1;
        end else if (r_issue) begin
            if (r_cnt == LAST_IDX) begin
                n_issue = 1'b0;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cap     <= '0;
            r_valid   <= '0;
            r_used    <= '0;
            r_issue   <= 1'b0;
            r_proc    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cap     <= n_cap;
            r_valid   <= n_valid;
            r_used    <= n_used;
            r_issue   <= n_issue;
            r_proc    <= n_proc;
            r_out_vld <= n_out_vld;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_kind      <= n_kind;
        r_key       <= n_key;
        r_color     <= n_color;
        r_frame     <= n_frame;
        r_dok       <= n_dok;
        r_cnt       <= n_cnt;
        r_pidx      <= n_pidx;
        r_hit_f     <= n_hit_f;
        r_hit_slot  <= n_hit_slot;
        r_hit_rank  <= n_hit_rank;
        r_tail_f    <= n_tail_f;
        r_tail_slot <= n_tail_slot;
        r_tail_rank <= n_tail_rank;
        r_free_f    <= n_free_f;
        r_free_slot <= n_free_slot;
        r_mode      <= n_mode;
        r_urank     <= n_urank;
        r_uslot     <= n_uslot;
        r_ins_slot  <= n_ins_slot;
        r_status    <= n_status;
        r_slot      <= n_slot;
        r_ev        <= n_ev;
        r_evslot    <= n_evslot;
        r_removed   <= n_removed;
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        r_rd_entry <= mem_entry[r_cnt];
        if (r_state == ST_INSERT) begin
            mem_entry[r_ins_slot] <= '{kind: r_kind, key: r_key, color: r_color,
                                       frame: r_frame};
        end
    end

    // rank memory
    always_ff @(posedge i_clk) begin
        r_rd_rank <= mem_rank[r_cnt];
        if (rank_we) begin
            mem_rank[rank_addr] <= rank_data;
        end
    end

    // outputs
    assign busy            = (r_state != ST_IDLE);
    assign o_valid         = r_out_vld;
    assign o_status        = r_status;
    assign o_slot          = SLOT_W'(r_slot);
    assign o_evicted       = r_ev;
    assign o_evicted_slot  = SLOT_W'(r_evslot);
    assign o_removed_count = COUNT_W'(r_removed);
    assign o_entries_used  = COUNT_W'(r_used);

    // checks
    `ASSERT_ALWAYS(a_used_matches_valid, i_clk, i_rst_n, $countones(r_valid) == int'(r_used))
    `ASSERT_ALWAYS(a_used_bound, i_clk, i_rst_n, r_used <= DEPTH_CNT)
    `ASSERT_IMPLIES(a_result_when_idle, i_clk, i_rst_n, o_valid, !busy)
    `ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, start && !busy, busy || o_valid)

endmodule

@@ sim/lru_keyed_entry_cache_tb.sv @@
// self-checking testbench of the lru keyed entry cache directory
`timescale 1ns / 1ps

module lru_keyed_entry_cache_tb;
    import lrukec_pkg::*;

    localparam int DIR_DEPTH    = DEFAULT_DEPTH;
    localparam int STALL_LIMIT  = 5000;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 2 * DIR_DEPTH + 8;
    localparam int POOL_KEYS    = 8;

    // opcodes with no operation behind them
    localparam logic [OPCODE_W-1:0] OP_SPARE_LO  = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_SPARE_MID = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_HI  = 3'd7;

    // source kinds that never match
    localparam logic [KIND_W-1:0] KIND_OTHER    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OTHER_HI = 2'd3;

    // one result beat
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic                evicted;
        logic [SLOT_W-1:0]   evicted_slot;
        logic [COUNT_W-1:0]  removed;
        logic [COUNT_W-1:0]  used;
    } t_outcome;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [CAP_W-1:0]           i_cfg_wdata;
    logic                       start;
    logic                       busy;
    logic [OPCODE_W-1:0]        i_opcode;
    logic [KIND_W-1:0]          i_key_kind;
    logic [KEY_W-1:0]           i_source_key;
    logic [COLOR_W-1:0]         i_color;
    logic signed [FRAME_W-1:0]  i_frame_number;
    logic                       i_decode_ok;
    logic                       o_valid;
    logic [STATUS_W-1:0]        o_status;
    logic [SLOT_W-1:0]          o_slot;
    logic                       o_evicted;
    logic [SLOT_W-1:0]          o_evicted_slot;
    logic [COUNT_W-1:0]         o_removed_count;
    logic [COUNT_W-1:0]         o_entries_used;

    lru_keyed_entry_cache #(
        .DEPTH(DIR_DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_key_kind     (i_key_kind),
        .i_source_key   (i_source_key),
        .i_color        (i_color),
        .i_frame_number (i_frame_number),
        .i_decode_ok    (i_decode_ok),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_evicted      (o_evicted),
        .o_evicted_slot (o_evicted_slot),
        .o_removed_count(o_removed_count),
        .o_entries_used (o_entries_used)
    );

    // mirror of the directory
    logic              dir_valid [DIR_DEPTH];
    logic [KIND_W-1:0] dir_kind  [DIR_DEPTH];
    logic [KEY_W-1:0]  dir_key   [DIR_DEPTH];
    logic [COLOR_W-1:0] dir_color [DIR_DEPTH];
    logic [FRAME_W-1:0] dir_frame [DIR_DEPTH];
    int unsigned       dir_rank  [DIR_DEPTH];
    int unsigned       dir_used;
    logic [CAP_W-1:0]  dir_capacity;

    // results still owed by the block, oldest first
    t_outcome cache_outcomes [$];
    int       mismatch_count;
    int       stall_cycles;
    int       sender_idle_pct;
    t_outcome seen;

    // stimulus pools, refilled per phase
    logic [KEY_W-1:0]   key_pool   [POOL_KEYS];
    logic [COLOR_W-1:0] color_pool [2];
    logic [FRAME_W-1:0] frame_pool [2];

    assign seen = {o_status, o_slot, o_evicted, o_evicted_slot, o_removed_count,
                   o_entries_used};

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // directory mirror helpers
    function automatic void clear_directory();
        for (int i = 0; i < DIR_DEPTH; i++) begin
            dir_valid[i] = 1'b0;
            dir_rank[i]  = 0;
        end
        dir_used     = 0;
        dir_capacity = '0;
    endfunction

    function automatic logic key_matches(int i, logic [KIND_W-1:0] kind,
                                         logic [KEY_W-1:0] key);
        return (kind == KIND_VAR || kind == KIND_FILE) && dir_kind[i] == kind
               && dir_key[i] == key;
    endfunction

    // drop one entry and close the gap in the ranks
    function automatic void unlink_slot(int s);
        int unsigned r;
        r = dir_rank[s];
        for (int i = 0; i < DIR_DEPTH; i++) begin
            if (dir_valid[i] && dir_rank[i] > r) dir_rank[i]--;
        end
        dir_valid[s] = 1'b0;
        if (dir_used > 0) dir_used--;
    endfunction

    // drop the least recent entry, -1 when empty
    function automatic int evict_oldest();
        int oldest;
        oldest = -1;
        for (int i = 0; i < DIR_DEPTH; i++) begin
            if (dir_valid[i] && (oldest < 0 || dir_rank[i] > dir_rank[oldest])) oldest = i;
        end
        if (oldest >= 0) unlink_slot(oldest);
        return oldest;
    endfunction

    // update the mirror with one command and return its result beat
    function automatic t_outcome apply_cache_op(logic [OPCODE_W-1:0] op,
                                                logic [KIND_W-1:0] kind,
                                                logic [KEY_W-1:0] key,
                                                logic [COLOR_W-1:0] color,
                                                logic [FRAME_W-1:0] frame,
                                                logic dok);
        t_outcome    res;
        int          hit;
        int          gone;
        int          free_slot;
        int unsigned cap_eff;
        res        = '0;
        res.status = STAT_DONE;
        cap_eff    = (dir_capacity < DIR_DEPTH) ? dir_capacity : DIR_DEPTH;
        case (op)
            OP_OPEN: begin
                if (cap_eff == 0) begin
                    res.status = STAT_DISABLED;
                end else begin
                    // most recent full match wins
                    hit = -1;
                    for (int i = 0; i < DIR_DEPTH; i++) begin
                        if (dir_valid[i] && dir_color[i] == color && dir_frame[i] == frame
                            && key_matches(i, kind, key)
                            && (hit < 0 || dir_rank[i] < dir_rank[hit]))
                            hit = i;
                    end
                    if (hit >= 0) begin
                        for (int i = 0; i < DIR_DEPTH; i++) begin
                            if (dir_valid[i] && dir_rank[i] < dir_rank[hit]) dir_rank[i]++;
                        end
                        dir_rank[hit] = 0;
                        res.status    = STAT_HIT;
                        res.slot      = SLOT_W'(hit);
                    end else if (!dok) begin
                        res.status = STAT_OPEN_FAILED;
                    end else begin
                        // full: make room first
                        if (dir_used >= cap_eff) begin
                            gone = evict_oldest();
                            if (gone >= 0) begin
                                res.evicted      = 1'b1;
                                res.evicted_slot = SLOT_W'(gone);
                                res.removed      = COUNT_W'(1);
                            end
                        end
                        free_slot = -1;
                        for (int i = 0; i < DIR_DEPTH; i++) begin
                            if (!dir_valid[i] && free_slot < 0) free_slot = i;
                        end
                        if (free_slot >= 0) begin
                            for (int i = 0; i < DIR_DEPTH; i++) begin
                                if (dir_valid[i]) dir_rank[i]++;
                            end
                            dir_valid[free_slot] = 1'b1;
                            dir_kind[free_slot]  = kind;
                            dir_key[free_slot]   = key;
                            dir_color[free_slot] = color;
                            dir_frame[free_slot] = frame;
                            dir_rank[free_slot]  = 0;
                            dir_used++;
                            res.slot = SLOT_W'(free_slot);
                        end
                        res.status = STAT_INSERTED;
                    end
                end
            end
            OP_INV_KEY, OP_INV_ALL: begin
                for (int i = 0; i < DIR_DEPTH; i++) begin
                    if (dir_valid[i] && (op == OP_INV_ALL || key_matches(i, kind, key))) begin
                        unlink_slot(i);
                        res.removed++;
                    end
                end
            end
            OP_TRIM: begin
                while (dir_used > dir_capacity && evict_oldest() >= 0) res.removed++;
            end
            OP_EVICT: begin
                if (evict_oldest() >= 0) res.removed = COUNT_W'(1);
                else res.status = STAT_NO_EVICT;
            end
            default: ;
        endcase
        res.used = COUNT_W'(dir_used);
        return res;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_valid) begin
            if (cache_outcomes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result beat: status %0d slot %0d used %0d",
                             seen.status, seen.slot, seen.used);
            end else begin
                want = cache_outcomes.pop_front();
                if (seen.status !== want.status || seen.slot !== want.slot
                    || seen.evicted !== want.evicted
                    || seen.evicted_slot !== want.evicted_slot
                    || seen.removed !== want.removed || seen.used !== want.used) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"result mismatch (expected/actual): status %0d/%0d ",
                                  "slot %0d/%0d evicted %0b/%0b evicted_slot %0d/%0d ",
                                  "removed %0d/%0d used %0d/%0d"},
                                 want.status, seen.status, want.slot, seen.slot,
                                 want.evicted, seen.evicted, want.evicted_slot,
                                 seen.evicted_slot, want.removed, seen.removed,
                                 want.used, seen.used);
                end
            end
        end
    end

    // watchdog on cycles with no beat taken
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("lru_keyed_entry_cache_tb NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // send one command beat, with random idle cycles ahead of it
    task automatic issue_command(input logic [OPCODE_W-1:0] op,
                                 input logic [KIND_W-1:0] kind,
                                 input logic [KEY_W-1:0] key,
                                 input logic [COLOR_W-1:0] color,
                                 input logic [FRAME_W-1:0] frame,
                                 input logic dok);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            start          = 1'b0;
            i_opcode       = OPCODE_W'($urandom);
            i_key_kind     = KIND_W'($urandom);
            i_source_key   = $urandom;
            i_color        = $urandom;
            i_frame_number = $urandom;
            i_decode_ok    = 1'($urandom);
            @(negedge i_clk);
        end
        start          = 1'b1;
        i_opcode       = op;
        i_key_kind     = kind;
        i_source_key   = key;
        i_color        = color;
        i_frame_number = frame;
        i_decode_ok    = dok;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        cache_outcomes.push_back(apply_cache_op(op, kind, key, color, frame, dok));
    endtask

    // stop sending and wait until every result is in
    task automatic settle_idle();
        @(negedge i_clk);
        start = 1'b0;
        while (cache_outcomes.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        settle_idle();
        @(negedge i_clk);
        i_cfg_we     = 1'b1;
        i_cfg_wdata  = value;
        dir_capacity = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // capacity zero after reset, empty directory, unused opcodes
    task automatic test_disabled_cache();
        sender_idle_pct = 0;
        issue_command(OP_OPEN, KIND_VAR, '0, '0, '0, 1'b1);
        issue_command(OP_OPEN, KIND_FILE, '1, '1, '1, 1'b0);
        issue_command(OP_EVICT, KIND_VAR, '0, '0, '0, 1'b0);
        issue_command(OP_TRIM, KIND_VAR, '0, '0, '0, 1'b0);
        issue_command(OP_SPARE_LO, KIND_FILE, '1, '0, '0, 1'b1);
        issue_command(OP_SPARE_MID, KIND_VAR, '0, '1, '1, 1'b0);
        issue_command(OP_SPARE_HI, KIND_OTHER_HI, '1, '1, '1, 1'b1);
    endtask

    // failed decode, insert, hit, full cache, kinds that never match
    task automatic test_open_paths();
        write_capacity(5'd2);
        issue_command(OP_OPEN, KIND_VAR, '0, '0, 32'h8000_0000, 1'b0);
        issue_command(OP_OPEN, KIND_VAR, '0, '0, 32'h8000_0000, 1'b1);
        issue_command(OP_OPEN, KIND_FILE, '1, '1, 32'h7fff_ffff, 1'b1);
        issue_command(OP_OPEN, KIND_VAR, '0, '0, 32'h8000_0000, 1'b0);
        issue_command(OP_OPEN, KIND_OTHER, '0, '0, 32'h8000_0000, 1'b1);
        issue_command(OP_OPEN, KIND_OTHER, '0, '0, 32'h8000_0000, 1'b1);
        issue_command(OP_INV_KEY, KIND_OTHER, '0, '0, '0, 1'b0);
        issue_command(OP_EVICT, KIND_VAR, '0, '0, '0, 1'b0);
        issue_command(OP_EVICT, KIND_VAR, '0, '0, '0, 1'b0);
    endtask

    // entries stay when capacity drops until a trim
    task automatic test_capacity_lowered();
        write_capacity(5'd16);
        for (int i = 0; i < 4; i++)
            issue_command(OP_OPEN, KIND_FILE, KEY_W'(i + 1), '0, '0, 1'b1);
        write_capacity(5'd2);
        issue_command(OP_OPEN, KIND_VAR, 32'h5a5a_a5a5, '1, '0, 1'b1);
        issue_command(OP_TRIM, KIND_VAR, '0, '0, '0, 1'b0);
        write_capacity(5'd31);
        issue_command(OP_OPEN, KIND_VAR, 32'h5a5a_a5a5, '1, '0, 1'b0);
        issue_command(OP_INV_ALL, KIND_VAR, '0, '0, '0, 1'b0);
    endtask

    // one random phase at a given capacity, idle rate and key spread
    task automatic run_random_phase(input logic [CAP_W-1:0] cap, input int n,
                                    input int idle_pct, input int spread);
        int                  roll;
        logic [OPCODE_W-1:0] op;
        logic [KIND_W-1:0]   kind;
        logic [KEY_W-1:0]    key;
        logic [COLOR_W-1:0]  color;
        logic [FRAME_W-1:0]  frame;
        write_capacity(cap);
        sender_idle_pct = idle_pct;
        foreach (key_pool[i]) key_pool[i] = $urandom;
        foreach (color_pool[i]) color_pool[i] = $urandom;
        foreach (frame_pool[i]) frame_pool[i] = $urandom;
        repeat (n) begin
            roll = $urandom_range(99);
            if (roll < 68) op = OP_OPEN;
            else if (roll < 76) op = OP_INV_KEY;
            else if (roll < 78) op = OP_INV_ALL;
            else if (roll < 84) op = OP_TRIM;
            else if (roll < 95) op = OP_EVICT;
            else if (roll < 97) op = OP_SPARE_LO;
            else if (roll < 98) op = OP_SPARE_MID;
            else op = OP_SPARE_HI;
            roll = $urandom_range(99);
            if (roll < 45) kind = KIND_VAR;
            else if (roll < 90) kind = KIND_FILE;
            else if (roll < 95) kind = KIND_OTHER;
            else kind = KIND_OTHER_HI;
            key   = ($urandom_range(9) == 0) ? KEY_W'($urandom)
                                             : key_pool[$urandom_range(spread - 1)];
            color = ($urandom_range(9) == 0) ? COLOR_W'($urandom)
                                             : color_pool[$urandom_range(1)];
            frame = ($urandom_range(9) == 0) ? FRAME_W'($urandom)
                                             : frame_pool[$urandom_range(1)];
            issue_command(op, kind, key, color, frame, $urandom_range(99) < 85);
        end
    endtask

    // random traffic over several capacities and idle rates
    task automatic test_random_traffic();
        run_random_phase(5'd16, 250, 0, 8);
        run_random_phase(5'd1, 150, 60, 3);
        run_random_phase(5'd31, 250, 11, POOL_KEYS);
        run_random_phase(5'd4, 200, 0, 4);
        run_random_phase(5'd0, 50, 11, 4);
        run_random_phase(CAP_W'($urandom_range(16, 1)), 300, 60, 6);
        run_random_phase(5'd8, 300, 11, 2);
        run_random_phase(5'd16, 280, 0, 1);
    endtask

    // main sequence
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        start           = 1'b0;
        i_opcode        = OP_OPEN;
        i_key_kind      = KIND_VAR;
        i_source_key    = '0;
        i_color         = '0;
        i_frame_number  = '0;
        i_decode_ok     = 1'b0;
        mismatch_count  = 0;
        stall_cycles    = 0;
        sender_idle_pct = 0;
        clear_directory();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_disabled_cache();
        test_open_paths();
        test_capacity_lowered();
        test_random_traffic();

        // drain, then watch for stray beats
        settle_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && cache_outcomes.size() == 0) begin
            $display("lru_keyed_entry_cache_tb OK");
        end else begin
            $display("lru_keyed_entry_cache_tb NOT OK");
        end
        $finish;
    end

endmodule
